// File: rtl/core/pba_pkg.sv
// Shared types, constants and helper functions for the page bitmap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package pba_pkg;

  localparam int CNT_W   = 13;
  localparam int PAGE_W  = 12;
  localparam int PID_W   = 16;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int ROW_N   = 128;
  localparam int ROW_W   = 7;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 48;
  localparam int OUT_USED_W = STAT_W + PAGE_W + 1 + CNT_W + CNT_W;

  localparam logic [CNT_W-1:0] MAX_PAGES  = 13'd4096;
  localparam logic [CNT_W-1:0] SYS_PAGES  = 13'd3;
  localparam logic [CNT_W-1:0] LIMIT_RST  = 13'd4096;
  localparam logic [WORD_W-1:0] ROW0_RST  = 32'h0000_0007;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;

  localparam logic [1:0] RD_SCAN0 = 2'd0;
  localparam logic [1:0] RD_TOTAL = 2'd1;
  localparam logic [1:0] RD_PID   = 2'd2;
  localparam logic [1:0] RD_NEXT  = 2'd3;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_GROW  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  typedef struct packed {
    logic              item_load;
    logic              rd_en;
    logic [1:0]        rd_src;
    logic              wr_en;
    logic [1:0]        wr_op;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              set_alloc;
    logic              out_load;
  } pba_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              free_zero;
    logic              can_grow;
    logic              pid_in_range;
    logic              pid_sys;
    logic              word_full;
    logic              pid_bit;
    logic              out_free;
  } pba_sts_t;

  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the allocator datapath for the page map.
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pba_ctrl.sv
// Controller state machine of the page bitmap allocator.
// Depends on pba_pkg; drives the datapath through pba_cmd_t and reads pba_sts_t.
module pba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pba_pkg::pba_sts_t sts_i,
  output pba_pkg::pba_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_START;
        end
      end
      S_START: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = pba_pkg::ST_OK;
        state_d          = S_DONE;
        case (sts_i.mode)
          pba_pkg::MODE_ALLOC: begin
            if (!sts_i.free_zero) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = pba_pkg::RD_SCAN0;
              state_d      = S_CHECK;
            end else if (sts_i.can_grow) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = pba_pkg::RD_TOTAL;
              state_d      = S_CHECK;
            end else begin
              cmd_o.status = pba_pkg::ST_NOSPACE;
            end
          end
          pba_pkg::MODE_FREE: begin
            if (sts_i.pid_in_range && !sts_i.pid_sys) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = pba_pkg::RD_PID;
              state_d      = S_CHECK;
            end else begin
              cmd_o.status = pba_pkg::ST_INVALID;
            end
          end
          pba_pkg::MODE_QUERY: begin
            if (sts_i.pid_in_range) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = pba_pkg::RD_PID;
              state_d      = S_CHECK;
            end
          end
          default: begin
            cmd_o.status = pba_pkg::ST_INVALID;
          end
        endcase
      end
      S_CHECK: begin
        state_d = S_DONE;
        case (sts_i.mode)
          pba_pkg::MODE_ALLOC: begin
            if (sts_i.free_zero) begin
              cmd_o.wr_en = 1'b1;
              cmd_o.wr_op = pba_pkg::OP_GROW;
            end else if (sts_i.word_full) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = pba_pkg::RD_NEXT;
              state_d      = S_CHECK;
            end else begin
              cmd_o.wr_en = 1'b1;
              cmd_o.wr_op = pba_pkg::OP_ALLOC;
            end
          end
          pba_pkg::MODE_FREE: begin
            if (sts_i.pid_bit) begin
              cmd_o.wr_en = 1'b1;
              cmd_o.wr_op = pba_pkg::OP_FREE;
            end else begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = pba_pkg::ST_INVALID;
            end
          end
          pba_pkg::MODE_QUERY: begin
            cmd_o.set_alloc = 1'b1;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/pba_dp.sv
// Datapath of the page bitmap allocator: item registers, counters, page map RAM
// with per-row valid bits, and the output register. Depends on pba_pkg and pba_ram.
module pba_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pba_pkg::pba_cmd_t                cmd_i,
  output pba_pkg::pba_sts_t                sts_o,
  input  logic [pba_pkg::MODE_W-1:0]       mode_i,
  input  logic [pba_pkg::PID_W-1:0]        page_id_i,
  input  logic [pba_pkg::CNT_W-1:0]        limit_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [pba_pkg::OUT_W-1:0]        out_data_o
);

  logic [pba_pkg::MODE_W-1:0] mode_q;
  logic [pba_pkg::PID_W-1:0]  pid_q;
  logic [pba_pkg::CNT_W-1:0]  total_q, free_q;
  logic [pba_pkg::ROW_W-1:0]  row_q, rd_addr;
  logic [pba_pkg::ROW_N-1:0]  row_valid_q;
  logic                       rd_valid_q, rd_zero_q;
  logic [pba_pkg::WORD_W-1:0] ram_rdata, word, wdata;
  logic [pba_pkg::BIT_W-1:0]  fz;
  logic [pba_pkg::STAT_W-1:0] status_q;
  logic [pba_pkg::PAGE_W-1:0] page_q;
  logic                       alloc_q;
  logic                       out_valid_q;
  logic [pba_pkg::OUT_W-1:0]  out_data_q;

  always_comb begin
    case (cmd_i.rd_src)
      pba_pkg::RD_SCAN0: rd_addr = '0;
      pba_pkg::RD_TOTAL: rd_addr = total_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
      pba_pkg::RD_PID:   rd_addr = pid_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
      pba_pkg::RD_NEXT:  rd_addr = row_q + pba_pkg::ROW_W'(1);
      default:           rd_addr = '0;
    endcase
  end

  // Rows never written read as their reset contents.
  assign word = rd_valid_q ? ram_rdata : (rd_zero_q ? pba_pkg::ROW0_RST : '0);
  assign fz   = pba_pkg::first_zero(word);

  always_comb begin
    case (cmd_i.wr_op)
      pba_pkg::OP_ALLOC: wdata = word | (pba_pkg::WORD_W'(1) << fz);
      pba_pkg::OP_GROW:  wdata = word | (pba_pkg::WORD_W'(1) << total_q[pba_pkg::BIT_W-1:0]);
      pba_pkg::OP_FREE:  wdata = word & ~(pba_pkg::WORD_W'(1) << pid_q[pba_pkg::BIT_W-1:0]);
      default:           wdata = word;
    endcase
  end

  pba_ram #(
    .WIDTH(pba_pkg::WORD_W),
    .DEPTH(pba_pkg::ROW_N)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(row_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      mode_q <= mode_i;
      pid_q  <= page_id_i;
    end
    if (cmd_i.rd_en) begin
      row_q      <= rd_addr;
      rd_valid_q <= row_valid_q[rd_addr];
      rd_zero_q  <= (rd_addr == '0);
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.item_load) begin
      page_q  <= '0;
      alloc_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en && cmd_i.wr_op == pba_pkg::OP_ALLOC) begin
        page_q <= {row_q, fz};
      end else if (cmd_i.wr_en && cmd_i.wr_op == pba_pkg::OP_GROW) begin
        page_q <= total_q[pba_pkg::PAGE_W-1:0];
      end
      if (cmd_i.set_alloc) begin
        alloc_q <= word[pid_q[pba_pkg::BIT_W-1:0]];
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= {(pba_pkg::OUT_W - pba_pkg::OUT_USED_W)'(0),
                     total_q, free_q, alloc_q, page_q, status_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= pba_pkg::SYS_PAGES;
      free_q      <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        row_valid_q[row_q] <= 1'b1;
        case (cmd_i.wr_op)
          pba_pkg::OP_ALLOC: free_q  <= free_q - pba_pkg::CNT_W'(1);
          pba_pkg::OP_GROW:  total_q <= total_q + pba_pkg::CNT_W'(1);
          pba_pkg::OP_FREE:  free_q  <= free_q + pba_pkg::CNT_W'(1);
          default:           free_q  <= free_q;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.mode         = mode_q;
  assign sts_o.free_zero    = (free_q == '0);
  assign sts_o.can_grow     = (total_q < limit_i) && (total_q < pba_pkg::MAX_PAGES);
  assign sts_o.pid_in_range = (pid_q < pba_pkg::PID_W'(total_q));
  assign sts_o.pid_sys      = (pid_q < pba_pkg::PID_W'(pba_pkg::SYS_PAGES));
  assign sts_o.word_full    = &word;
  assign sts_o.pid_bit      = word[pid_q[pba_pkg::BIT_W-1:0]];
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/core/page_bitmap_allocator.sv
// Page bitmap allocator top level: stream ports, APB page limit register, assertions.
// Sequence: accept, then a start state that checks the item and may read a map row, then
// a check state, repeated for each 32-bit map row an allocate scans (at most 128), then
// a done state that loads the result. One item at a time; the next item can be accepted
// in the cycle after the result is loaded, and the result waits while the output stalls.
// Reset: asynchronous; pages 0 to 2 in use, total 3, free 0, limit 4096; no clearing pass.
module page_bitmap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // mode[1:0], page_id[17:2], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // status[1:0], result_page[13:2], allocated[14],
                                      // free_count[27:15], total_count[40:28], zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pba_pkg::pba_cmd_t          cmd;
  pba_pkg::pba_sts_t          sts;
  logic [pba_pkg::CNT_W-1:0]  limit_q;
  logic                       in_ready;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : 32'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= pba_pkg::LIMIT_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      limit_q <= pwdata[pba_pkg::CNT_W-1:0];
    end
  end

  pba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pba_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .mode_i     (s_axis_tdata[1:0]),
    .page_id_i  (s_axis_tdata[17:2]),
    .limit_i    (limit_q),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

  assign s_axis_tready = in_ready;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[40:28] <= pba_pkg::MAX_PAGES)
    else $error("total_count above the map size");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[27:15] <= m_axis_tdata[40:28])
    else $error("free_count exceeds total_count");

  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[13:2] != '0) |->
      (m_axis_tdata[1:0] == pba_pkg::ST_OK && 13'(m_axis_tdata[13:2]) < m_axis_tdata[40:28]
       && m_axis_tdata[13:2] > 12'd2))
    else $error("granted page outside the store or a system page");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("undefined status code");

endmodule
